/* hdl/scsa_pkg.sv */
// ----------------------------------------------------------------------------
// scsa_pkg
// Types, codes and layout helpers for the size-class slot allocator.
// ----------------------------------------------------------------------------
package scsa_pkg;

  // default pool layout
  localparam int unsigned SmallSlotsDef  = 20;
  localparam int unsigned MediumSlotsDef = 5;
  localparam int unsigned LargeSlotsDef  = 3;
  localparam int unsigned SmallTilesDef  = 16;
  localparam int unsigned MediumTilesDef = 24;
  localparam int unsigned LargeTilesDef  = 32;

  localparam int unsigned TileW = 9;

  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE     = 2'd1,
    OP_FREE_ALL = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    SC_SMALL  = 2'd0,
    SC_MEDIUM = 2'd1,
    SC_LARGE  = 2'd2,
    SC_BAD    = 2'd3
  } size_class_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NO_SLOT   = 2'd2,
    ST_BAD_CLASS = 2'd3
  } status_e;

  typedef struct packed {
    opcode_e          opcode;
    size_class_e      size_class;
    logic [TileW-1:0] release_tile;
  } req_t;

  typedef struct packed {
    logic [TileW-1:0] start_tile;
    status_e          status;
  } rsp_t;

  // start tile of slot s at full width; pools are laid out small, medium, large
  function automatic int unsigned slot_start(
    input int unsigned s,
    input int unsigned small_slots,
    input int unsigned medium_slots,
    input int unsigned small_tiles,
    input int unsigned medium_tiles,
    input int unsigned large_tiles
  );
    int unsigned small_end;
    int unsigned medium_end;
    int unsigned res;
    small_end  = small_slots * small_tiles;
    medium_end = small_end + medium_slots * medium_tiles;
    if (s < small_slots) begin
      res = s * small_tiles;
    end else if (s < small_slots + medium_slots) begin
      res = small_end + (s - small_slots) * medium_tiles;
    end else begin
      res = medium_end + (s - small_slots - medium_slots) * large_tiles;
    end
    return res;
  endfunction

endpackage

/* hdl/size_class_slot_allocator.sv */
// ----------------------------------------------------------------------------
// size_class_slot_allocator
// Segregated-fit slot allocator: one taken flag per slot over three pools.
// ----------------------------------------------------------------------------
// Path: a request is held in the request register, then its response in the
// response register; a stalled response holds the next request in place.
// Throughput: one request per cycle while responses are taken; the find-first
// over a pool's flags and the start-tile match sit between the two registers.
// Reset: all slots free, both stages empty; the block takes a request as soon
// as reset is released.
module size_class_slot_allocator
  import scsa_pkg::*;
#(
  parameter int unsigned SMALL_SLOTS  = SmallSlotsDef,
  parameter int unsigned MEDIUM_SLOTS = MediumSlotsDef,
  parameter int unsigned LARGE_SLOTS  = LargeSlotsDef,
  parameter int unsigned SMALL_TILES  = SmallTilesDef,
  parameter int unsigned MEDIUM_TILES = MediumTilesDef,
  parameter int unsigned LARGE_TILES  = LargeTilesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  localparam int unsigned TotalSlots = SMALL_SLOTS + MEDIUM_SLOTS + LARGE_SLOTS;
  localparam int unsigned SlotW      = $clog2(TotalSlots);
  localparam int unsigned MediumBase = SMALL_SLOTS;
  localparam int unsigned LargeBase  = SMALL_SLOTS + MEDIUM_SLOTS;

  logic                  req_valid_q, req_valid_d;
  req_t                  req_q;
  logic                  rsp_valid_q, rsp_valid_d;
  rsp_t                  rsp_q, rsp_d;
  logic [TotalSlots-1:0] taken_q, taken_d;
  logic                  advance;

  assign advance     = req_valid_q && (!rsp_valid_q || rsp_ready_i);
  assign req_ready_o = !req_valid_q || advance;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  always_comb begin
    req_valid_d = req_valid_q;
    if (req_valid_i && req_ready_o) begin
      req_valid_d = 1'b1;
    end else if (advance) begin
      req_valid_d = 1'b0;
    end
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (advance) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  // request processing against the flags
  always_comb begin
    int unsigned first;
    int unsigned last;
    logic             found;
    logic [SlotW-1:0] idx;
    logic             hit;
    logic [SlotW-1:0] hit_idx;
    taken_d          = taken_q;
    rsp_d.start_tile = '0;
    rsp_d.status     = ST_OK;
    first            = 0;
    last             = 0;
    found            = 1'b0;
    idx              = '0;
    hit              = 1'b0;
    hit_idx          = '0;
    case (req_q.opcode)
      OP_ALLOC: begin
        case (req_q.size_class)
          SC_SMALL: begin
            first = 0;
            last  = MediumBase;
          end
          SC_MEDIUM: begin
            first = MediumBase;
            last  = LargeBase;
          end
          SC_LARGE: begin
            first = LargeBase;
            last  = TotalSlots;
          end
          default: begin
            first = 0;
            last  = 0;
          end
        endcase
        // descending scan so the lowest free slot of the pool wins
        for (int s = int'(TotalSlots) - 1; s >= 0; s--) begin
          if (s >= int'(first) && s < int'(last) && !taken_q[s]) begin
            found = 1'b1;
            idx   = SlotW'(s);
          end
        end
        if (req_q.size_class == SC_BAD) begin
          rsp_d.status = ST_BAD_CLASS;
        end else if (!found) begin
          rsp_d.status = ST_FULL;
        end else begin
          taken_d[idx]     = 1'b1;
          rsp_d.start_tile = TileW'(slot_start(32'(idx), SMALL_SLOTS, MEDIUM_SLOTS,
                                               SMALL_TILES, MEDIUM_TILES, LARGE_TILES));
        end
      end
      OP_FREE: begin
        // start tiles are strictly increasing, so at most one slot matches
        for (int s = 0; s < int'(TotalSlots); s++) begin
          if (slot_start(s, SMALL_SLOTS, MEDIUM_SLOTS, SMALL_TILES, MEDIUM_TILES,
                         LARGE_TILES) == 32'(req_q.release_tile)) begin
            hit     = 1'b1;
            hit_idx = SlotW'(s);
          end
        end
        if (hit) begin
          taken_d[hit_idx] = 1'b0;
        end else begin
          rsp_d.status = ST_NO_SLOT;
        end
      end
      OP_FREE_ALL: begin
        taken_d = '0;
      end
      default: begin
        rsp_d.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
      taken_q     <= '0;
    end else begin
      req_valid_q <= req_valid_d;
      rsp_valid_q <= rsp_valid_d;
      if (advance) begin
        taken_q <= taken_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      req_q <= req_i;
    end
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

endmodule

/* tb/size_class_slot_allocator_tb.sv */
// ----------------------------------------------------------------------------
// size_class_slot_allocator_tb
// Drives allocate, free, free-all and unused requests into the slot allocator
// with random gaps on both channels and one long response stall. A tracker
// keeps its own copy of the slot taken flags, works out the response of each
// accepted request and checks the responses in order, field by field.
// ----------------------------------------------------------------------------
module size_class_slot_allocator_tb;
  import scsa_pkg::*;

  localparam int unsigned SmallSlots  = SmallSlotsDef;
  localparam int unsigned MediumSlots = MediumSlotsDef;
  localparam int unsigned LargeSlots  = LargeSlotsDef;
  localparam int unsigned SmallTiles  = SmallTilesDef;
  localparam int unsigned MediumTiles = MediumTilesDef;
  localparam int unsigned LargeTiles  = LargeTilesDef;
  localparam int unsigned TotalSlots  = SmallSlots + MediumSlots + LargeSlots;

  localparam logic [1:0] OpUnused = 2'd3;

  localparam int RandomItems   = 600;
  localparam int HoldCycles    = 90;
  localparam int HoldAfterRsp  = 250;
  localparam int DrainCycles   = 8;
  localparam int LimitCycles   = 400000;
  localparam int MaxReported   = 10;

  // tracks slot flags and the responses still owed by the block
  class slot_tracker;
    bit         taken [TotalSlots];
    rsp_t       owed_q[$];
    int         failures;
    int         rsp_seen;

    function new();
      foreach (taken[s]) taken[s] = 1'b0;
      failures = 0;
      rsp_seen = 0;
    endfunction

    function int unsigned tile_of(int unsigned s);
      int unsigned small_end;
      int unsigned medium_end;
      small_end  = SmallSlots * SmallTiles;
      medium_end = small_end + MediumSlots * MediumTiles;
      if (s < SmallSlots) return s * SmallTiles;
      if (s < SmallSlots + MediumSlots) return small_end + (s - SmallSlots) * MediumTiles;
      return medium_end + (s - SmallSlots - MediumSlots) * LargeTiles;
    endfunction

    function void note_request(req_t req);
      rsp_t        want;
      int unsigned lo;
      int unsigned hi;
      int unsigned full_tile;
      bit          found;
      want.start_tile = '0;
      want.status     = ST_OK;
      lo    = 0;
      hi    = 0;
      found = 1'b0;
      case (req.opcode)
        OP_ALLOC: begin
          case (req.size_class)
            SC_SMALL: begin
              lo = 0;
              hi = SmallSlots;
            end
            SC_MEDIUM: begin
              lo = SmallSlots;
              hi = SmallSlots + MediumSlots;
            end
            SC_LARGE: begin
              lo = SmallSlots + MediumSlots;
              hi = TotalSlots;
            end
            default: want.status = ST_BAD_CLASS;
          endcase
          if (want.status == ST_OK) begin
            want.status = ST_FULL;
            for (int unsigned s = lo; s < hi; s++) begin
              if (!found && !taken[s]) begin
                found           = 1'b1;
                taken[s]        = 1'b1;
                full_tile       = tile_of(s);
                want.start_tile = full_tile[TileW-1:0];
                want.status     = ST_OK;
              end
            end
          end
        end
        OP_FREE: begin
          want.status = ST_NO_SLOT;
          for (int unsigned s = 0; s < TotalSlots; s++) begin
            if (!found && tile_of(s) == int'(req.release_tile)) begin
              found       = 1'b1;
              taken[s]    = 1'b0;
              want.status = ST_OK;
            end
          end
        end
        OP_FREE_ALL: begin
          foreach (taken[s]) taken[s] = 1'b0;
        end
        default: ;
      endcase
      owed_q.push_back(want);
    endfunction

    function void flag_failure(string what);
      failures++;
      if (failures <= MaxReported) $display("mismatch: %s", what);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      rsp_seen++;
      if (owed_q.size() == 0) begin
        flag_failure($sformatf("response with none owed: start_tile=%0d status=%0d",
                               got.start_tile, got.status));
        return;
      end
      want = owed_q.pop_front();
      if (got.start_tile !== want.start_tile)
        flag_failure($sformatf("start_tile expected %0d got %0d",
                               want.start_tile, got.start_tile));
      if (got.status !== want.status)
        flag_failure($sformatf("status expected %0d got %0d", want.status, got.status));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic req_valid_i;
  logic req_ready_o;
  req_t req_i;
  logic rsp_valid_o;
  logic rsp_ready_i;
  rsp_t rsp_o;

  slot_tracker tracker = new();
  int          cycles  = 0;
  bit          hold_done = 1'b0;

  size_class_slot_allocator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && rsp_ready_i) tracker.check_response(rsp_o);
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic req_t make_req(logic [1:0] op, logic [1:0] cls, logic [TileW-1:0] tile);
    req_t r;
    r.opcode       = opcode_e'(op);
    r.size_class   = size_class_e'(cls);
    r.release_tile = tile;
    return r;
  endfunction

  // slot whose flag matches want_taken if there is one, else any slot
  function automatic int unsigned pick_slot(bit want_taken);
    int unsigned hits[$];
    foreach (tracker.taken[s]) if (tracker.taken[s] == want_taken) hits.push_back(s);
    if (hits.size() == 0) return $urandom_range(0, TotalSlots - 1);
    return hits[$urandom_range(0, hits.size() - 1)];
  endfunction

  function automatic req_t random_req(bit alloc_heavy);
    int          r;
    int unsigned s;
    int unsigned full_tile;
    logic [1:0]  junk_cls;
    logic [TileW-1:0] junk_tile;
    r         = $urandom_range(0, 99);
    junk_cls  = 2'($urandom_range(0, 3));
    junk_tile = TileW'($urandom_range(0, 511));
    if (r < (alloc_heavy ? 65 : 35)) begin
      return make_req(OP_ALLOC, 2'($urandom_range(0, 2)), junk_tile);
    end else if (r < 82) begin
      s = pick_slot($urandom_range(0, 9) < 7);
      full_tile = tracker.tile_of(s);
      return make_req(OP_FREE, junk_cls, full_tile[TileW-1:0]);
    end else if (r < 85) begin
      return make_req(OP_FREE_ALL, junk_cls, junk_tile);
    end else if (r < 91) begin
      return make_req(OP_FREE, junk_cls, junk_tile);
    end else if (r < 96) begin
      return make_req(OP_ALLOC, SC_BAD, junk_tile);
    end
    return make_req(OpUnused, junk_cls, junk_tile);
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_request(input req_t item, input bit quiet);
    int gap;
    req_i       = item;
    req_valid_i = 1'b1;
    do @(posedge clk_i); while (!req_ready_o);
    tracker.note_request(item);
    @(negedge clk_i);
    gap = pick_gap(quiet);
    if (gap > 0) begin
      req_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // response side: random ready with one long hold-off so the block backs up
  initial begin
    int gap;
    rsp_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!hold_done && tracker.rsp_seen >= HoldAfterRsp) begin
        rsp_ready_i = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
      end
      rsp_ready_i = 1'b1;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
      gap = pick_gap(((cycles / 300) % 3) == 2);
      if (gap > 0) begin
        rsp_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  end

  initial begin
    req_t directed_q[$];
    rst_ni      = 1'b0;
    req_valid_i = 1'b0;
    req_i       = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // first slot of each pool, bad class, ignored tile field at all ones
    directed_q.push_back(make_req(OP_ALLOC, SC_SMALL, 9'h1FF));
    directed_q.push_back(make_req(OP_ALLOC, SC_MEDIUM, 9'd0));
    directed_q.push_back(make_req(OP_ALLOC, SC_LARGE, 9'd0));
    directed_q.push_back(make_req(OP_ALLOC, SC_BAD, 9'h1FF));
    // fill the large pool past its end
    directed_q.push_back(make_req(OP_ALLOC, SC_LARGE, 9'd0));
    directed_q.push_back(make_req(OP_ALLOC, SC_LARGE, 9'd0));
    directed_q.push_back(make_req(OP_ALLOC, SC_LARGE, 9'd0));
    // frees: small and medium pool starts, last large slot, unknown tiles, already free slot
    directed_q.push_back(make_req(OP_FREE, SC_BAD, 9'd0));
    directed_q.push_back(make_req(OP_FREE, SC_SMALL, 9'd320));
    directed_q.push_back(make_req(OP_FREE, SC_SMALL, 9'd504));
    directed_q.push_back(make_req(OP_FREE, SC_SMALL, 9'h1FF));
    directed_q.push_back(make_req(OP_FREE, SC_SMALL, 9'd1));
    directed_q.push_back(make_req(OP_FREE, SC_SMALL, 9'd0));
    directed_q.push_back(make_req(OP_ALLOC, SC_LARGE, 9'd0));
    // unused opcode leaves the flags alone
    directed_q.push_back(make_req(OpUnused, SC_BAD, 9'h1FF));
    directed_q.push_back(make_req(OpUnused, SC_SMALL, 9'd0));
    directed_q.push_back(make_req(OP_FREE_ALL, SC_BAD, 9'h1FF));
    // medium pool to full, after free-all every slot is back
    repeat (6) directed_q.push_back(make_req(OP_ALLOC, SC_MEDIUM, 9'd0));
    directed_q.push_back(make_req(OP_ALLOC, SC_LARGE, 9'd0));
    directed_q.push_back(make_req(OP_FREE_ALL, SC_SMALL, 9'd0));

    @(negedge clk_i);
    foreach (directed_q[i]) send_request(directed_q[i], 1'b0);

    for (int i = 0; i < RandomItems; i++) begin
      send_request(random_req(((i / 100) % 2) == 0), ((i / 40) % 4) == 1);
    end
    req_valid_i = 1'b0;

    while (tracker.owed_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (tracker.failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/scsa_pkg.sv
hdl/size_class_slot_allocator.sv
tb/size_class_slot_allocator_tb.sv
